/* hw/rtl/random_patrol_speed_generator_core_defines.svh */
// assertion helpers shared by rpsg_datapath and rpsg_ctrl
`ifndef RANDOM_PATROL_SPEED_GENERATOR_CORE_DEFINES_SVH
`define RANDOM_PATROL_SPEED_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define RPSG_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RPSG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rpsg_pkg.sv */
package rpsg_pkg;

    // field widths
    localparam int PosW     = 32;
    localparam int TravelW  = 31;
    localparam int MarginW  = 20;
    localparam int SpanW    = 14;
    localparam int TspanW   = 16;
    localparam int WordW    = 31;
    localparam int TargetW  = 16;
    localparam int HoldW    = 17;
    localparam int FiltW    = 32;
    localparam int Q8W      = 24;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 31;

    // remainder unit: one quotient bit per cycle
    localparam int DivSteps = WordW;
    localparam int DivCntW  = $clog2(DivSteps);

    // filter weights in q0.16 and their complements
    localparam logic [15:0] WNormal  = 16'd64881;
    localparam logic [15:0] WEdge    = 16'd58982;
    localparam logic [12:0] WcNormal = 13'd655;
    localparam logic [12:0] WcEdge   = 13'd6554;

    // register reset values
    localparam logic [TravelW-1:0] TravelReset = 31'd100000;
    localparam logic [MarginW-1:0] MarginReset = 20'd1500;
    localparam logic [SpanW-1:0]   SpanReset   = 14'd1000;
    localparam logic [SpanW-1:0]   SminReset   = 14'd500;
    localparam logic [TspanW-1:0]  TspanReset  = 16'd1000;
    localparam logic [TspanW-1:0]  TminReset   = 16'd500;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TRAVEL_LENGTH = 3'd0,
        CFG_EDGE_MARGIN   = 3'd1,
        CFG_SPEED_SPAN    = 3'd2,
        CFG_SPEED_MIN     = 3'd3,
        CFG_TIME_SPAN     = 3'd4,
        CFG_TIME_MIN      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TravelW-1:0] travel_length;
        logic [MarginW-1:0] edge_margin;
        logic [SpanW-1:0]   speed_span;
        logic [SpanW-1:0]   speed_min;
        logic [TspanW-1:0]  time_span;
        logic [TspanW-1:0]  time_min;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DRAW,
        ST_EDGE,
        ST_MUL,
        ST_ACC,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic draw;
        logic edge_chk;
        logic mul;
        logic accum;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic need_draw;
        logic div_last;
    } dp_status_t;

endpackage

/* hw/rtl/rpsg_cfg_regs.sv */
module rpsg_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rpsg_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [rpsg_pkg::CfgDataW-1:0]     cfg_wdata,
    output rpsg_pkg::cfg_t                    cfg
);

    rpsg_pkg::cfg_t cfg_reg, cfg_next;

    // decode one register write, unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (rpsg_pkg::cfg_idx_t'(cfg_index))
                rpsg_pkg::CFG_TRAVEL_LENGTH: begin
                    cfg_next.travel_length = cfg_wdata[rpsg_pkg::TravelW-1:0];
                end
                rpsg_pkg::CFG_EDGE_MARGIN: begin
                    cfg_next.edge_margin = cfg_wdata[rpsg_pkg::MarginW-1:0];
                end
                rpsg_pkg::CFG_SPEED_SPAN: begin
                    cfg_next.speed_span = cfg_wdata[rpsg_pkg::SpanW-1:0];
                end
                rpsg_pkg::CFG_SPEED_MIN: begin
                    cfg_next.speed_min = cfg_wdata[rpsg_pkg::SpanW-1:0];
                end
                rpsg_pkg::CFG_TIME_SPAN: begin
                    cfg_next.time_span = cfg_wdata[rpsg_pkg::TspanW-1:0];
                end
                rpsg_pkg::CFG_TIME_MIN: begin
                    cfg_next.time_min = cfg_wdata[rpsg_pkg::TspanW-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.travel_length <= rpsg_pkg::TravelReset;
            cfg_reg.edge_margin   <= rpsg_pkg::MarginReset;
            cfg_reg.speed_span    <= rpsg_pkg::SpanReset;
            cfg_reg.speed_min     <= rpsg_pkg::SminReset;
            cfg_reg.time_span     <= rpsg_pkg::TspanReset;
            cfg_reg.time_min      <= rpsg_pkg::TminReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/rpsg_datapath.sv */
`include "random_patrol_speed_generator_core_defines.svh"

module rpsg_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rpsg_pkg::cfg_t                        cfg,
    input  rpsg_pkg::dp_cmd_t                     cmd,
    output rpsg_pkg::dp_status_t                  status,
    input  logic signed [rpsg_pkg::PosW-1:0]      s_position,
    input  logic                                  s_rand_direction,
    input  logic [rpsg_pkg::WordW-1:0]            s_rand_speed_word,
    input  logic [rpsg_pkg::WordW-1:0]            s_rand_time_word,
    output logic signed [rpsg_pkg::Q8W-1:0]       m_speed_command_q8,
    output logic signed [rpsg_pkg::TargetW-1:0]   m_target_speed,
    output logic                                  m_edge_reversed
);

    // latched tick inputs
    logic signed [rpsg_pkg::PosW-1:0]    pos_reg;
    logic                                dir_reg;
    logic [rpsg_pkg::WordW-1:0]          sword_reg;
    logic [rpsg_pkg::WordW-1:0]          tword_reg;

    // remainder unit
    logic [rpsg_pkg::SpanW-1:0]          srem_reg;
    logic [rpsg_pkg::TspanW-1:0]         trem_reg;
    logic [rpsg_pkg::DivCntW-1:0]        div_cnt_reg;

    // patrol state
    logic [rpsg_pkg::HoldW-1:0]          hold_counter_reg;
    logic [rpsg_pkg::HoldW-1:0]          hold_time_reg;
    logic signed [rpsg_pkg::TargetW-1:0] target_reg;
    logic                                rev_reg;
    logic signed [rpsg_pkg::FiltW-1:0]   filt_reg;

    // filter products
    logic signed [29:0]                  p1_reg;
    logic signed [48:0]                  p2_reg;

    // result registers
    logic signed [rpsg_pkg::Q8W-1:0]     q8_out_reg;
    logic signed [rpsg_pkg::TargetW-1:0] target_out_reg;
    logic                                rev_out_reg;

    // remainder step: shift in one dividend bit, subtract when it fits
    logic [rpsg_pkg::SpanW:0]            s_shift;
    logic [rpsg_pkg::TspanW:0]           t_shift;
    logic [rpsg_pkg::SpanW-1:0]          srem_next;
    logic [rpsg_pkg::TspanW-1:0]         trem_next;

    always_comb begin
        s_shift = {srem_reg, sword_reg[rpsg_pkg::WordW-1]};
        t_shift = {trem_reg, tword_reg[rpsg_pkg::WordW-1]};
        if (s_shift >= {1'b0, cfg.speed_span}) begin
            srem_next = rpsg_pkg::SpanW'(s_shift - {1'b0, cfg.speed_span});
        end else begin
            srem_next = s_shift[rpsg_pkg::SpanW-1:0];
        end
        if (t_shift >= {1'b0, cfg.time_span}) begin
            trem_next = rpsg_pkg::TspanW'(t_shift - {1'b0, cfg.time_span});
        end else begin
            trem_next = t_shift[rpsg_pkg::TspanW-1:0];
        end
    end

    // new target and hold time from the remainders, zero span gives a zero remainder
    logic [rpsg_pkg::SpanW-1:0]          smod;
    logic [rpsg_pkg::TspanW-1:0]         tmod;
    logic [rpsg_pkg::TargetW-1:0]        mag;
    logic [rpsg_pkg::HoldW-1:0]          ht;

    always_comb begin
        smod = (cfg.speed_span == '0) ? '0 : srem_reg;
        tmod = (cfg.time_span == '0) ? '0 : trem_reg;
        mag  = {2'b00, smod} + {2'b00, cfg.speed_min};
        ht   = {1'b0, tmod} + {1'b0, cfg.time_min};
    end

    // rail end tests on 34 bit signed values
    logic signed [33:0] pos_ext;
    logic signed [33:0] upper_lim;
    logic signed [33:0] lower_lim;
    logic               edge_hit;

    always_comb begin
        pos_ext   = {{2{pos_reg[rpsg_pkg::PosW-1]}}, pos_reg};
        lower_lim = $signed({14'd0, cfg.edge_margin});
        upper_lim = $signed({3'd0, cfg.travel_length}) - lower_lim;
        edge_hit  = ((pos_ext > upper_lim) && (target_reg > 0))
                 || ((pos_ext < lower_lim) && (target_reg < 0));
    end

    // filter products and accumulate with half-up rounding
    logic signed [29:0] p1_next;
    logic signed [48:0] p2_next;
    logic signed [49:0] acc_sum;
    logic signed [32:0] q8_sum;

    always_comb begin
        p1_next = 30'($signed({1'b0, (rev_reg ? rpsg_pkg::WcEdge : rpsg_pkg::WcNormal)}))
                * 30'(target_reg);
        p2_next = 49'($signed({1'b0, (rev_reg ? rpsg_pkg::WEdge : rpsg_pkg::WNormal)}))
                * 49'(filt_reg);
        acc_sum = $signed({{4{p1_reg[29]}}, p1_reg, 16'd0})
                + $signed({p2_reg[48], p2_reg})
                + 50'sd32768;
        q8_sum  = $signed({filt_reg[rpsg_pkg::FiltW-1], filt_reg}) + 33'sd128;
    end

    assign status.need_draw = (hold_counter_reg >= hold_time_reg);
    assign status.div_last  = (div_cnt_reg == rpsg_pkg::DivCntW'(rpsg_pkg::DivSteps - 1));

    // control-side state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_counter_reg <= '0;
            hold_time_reg    <= '0;
            target_reg       <= '0;
            filt_reg         <= '0;
            rev_reg          <= 1'b0;
            div_cnt_reg      <= '0;
        end else begin
            if (cmd.load_in) begin
                div_cnt_reg <= '0;
                rev_reg     <= 1'b0;
                if (status.need_draw) begin
                    hold_counter_reg <= '0;
                end else begin
                    hold_counter_reg <= hold_counter_reg + 1'b1;
                end
            end
            if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.draw) begin
                hold_time_reg <= ht;
                target_reg    <= dir_reg ? $signed(mag) : -$signed(mag);
            end
            if (cmd.edge_chk && edge_hit) begin
                target_reg <= -target_reg;
                rev_reg    <= 1'b1;
            end
            if (cmd.accum) begin
                filt_reg <= acc_sum[47:16];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pos_reg   <= s_position;
            dir_reg   <= s_rand_direction;
            sword_reg <= s_rand_speed_word;
            tword_reg <= s_rand_time_word;
            srem_reg  <= '0;
            trem_reg  <= '0;
        end else if (cmd.div_step) begin
            sword_reg <= {sword_reg[rpsg_pkg::WordW-2:0], 1'b0};
            tword_reg <= {tword_reg[rpsg_pkg::WordW-2:0], 1'b0};
            srem_reg  <= srem_next;
            trem_reg  <= trem_next;
        end
        if (cmd.mul) begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
        if (cmd.out_load) begin
            q8_out_reg     <= q8_sum[31:8];
            target_out_reg <= target_reg;
            rev_out_reg    <= rev_reg;
        end
    end

    assign m_speed_command_q8 = q8_out_reg;
    assign m_target_speed     = target_out_reg;
    assign m_edge_reversed    = rev_out_reg;

    `RPSG_ASSERT_NEXT(a_draw_clears_counter, aclk, aresetn,
        cmd.load_in && status.need_draw, hold_counter_reg == '0,
        "hold counter not cleared on draw")
    `RPSG_ASSERT_IMPL(a_speed_rem_below_span, aclk, aresetn,
        cmd.draw && (cfg.speed_span != '0), srem_reg < cfg.speed_span,
        "speed remainder not below span")
    `RPSG_ASSERT_IMPL(a_time_rem_below_span, aclk, aresetn,
        cmd.draw && (cfg.time_span != '0), trem_reg < cfg.time_span,
        "time remainder not below span")
    `RPSG_ASSERT_IMPL(a_counter_within_hold, aclk, aresetn,
        cmd.load_in && !status.need_draw, hold_counter_reg < hold_time_reg,
        "hold counter passed hold time")

endmodule

/* hw/rtl/rpsg_ctrl.sv */
`include "random_patrol_speed_generator_core_defines.svh"

module rpsg_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  logic                     m_ready,
    input  rpsg_pkg::dp_status_t     status,
    output rpsg_pkg::dp_cmd_t        cmd
);

    rpsg_pkg::ctrl_state_t state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rpsg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = status.need_draw ? rpsg_pkg::ST_DIV : rpsg_pkg::ST_EDGE;
                end
            end
            rpsg_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = rpsg_pkg::ST_DRAW;
                end
            end
            rpsg_pkg::ST_DRAW: state_next = rpsg_pkg::ST_EDGE;
            rpsg_pkg::ST_EDGE: state_next = rpsg_pkg::ST_MUL;
            rpsg_pkg::ST_MUL:  state_next = rpsg_pkg::ST_ACC;
            rpsg_pkg::ST_ACC:  state_next = rpsg_pkg::ST_OUT;
            rpsg_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = rpsg_pkg::ST_IDLE;
                end
            end
            default: state_next = rpsg_pkg::ST_IDLE;
        endcase
    end

    // datapath commands and handshake outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            rpsg_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            rpsg_pkg::ST_DIV:  cmd.div_step = 1'b1;
            rpsg_pkg::ST_DRAW: cmd.draw     = 1'b1;
            rpsg_pkg::ST_EDGE: cmd.edge_chk = 1'b1;
            rpsg_pkg::ST_MUL:  cmd.mul      = 1'b1;
            rpsg_pkg::ST_ACC:  cmd.accum    = 1'b1;
            rpsg_pkg::ST_OUT:  cmd.out_load = out_free;
            default: begin
                cmd     = '0;
                s_ready = 1'b0;
            end
        endcase
    end

    // output register valid
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rpsg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `RPSG_ASSERT_IMPL(a_load_only_when_free, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready, "result overwritten before transfer")
    `RPSG_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_valid && s_ready, state_reg == rpsg_pkg::ST_DIV || state_reg == rpsg_pkg::ST_EDGE, "accepted tick not started")
    `RPSG_ASSERT_NEXT(a_load_sets_valid, aclk, aresetn, cmd.out_load, m_valid_reg && state_reg == rpsg_pkg::ST_IDLE, "result load did not raise valid")

endmodule

/* hw/rtl/random_patrol_speed_generator_core.sv */
// a hold tick runs edge check, multiply, accumulate and result load; a draw tick first
// divides and draws a new target; a new tick is taken only once the last one is done
// the division runs on the shared remainder unit, one quotient bit per cycle over 31 bits
// a held result does not block the next input transfer, only the next result load
// reset (aresetn, synchronous, active low) restores register defaults and clears patrol state
module random_patrol_speed_generator_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [rpsg_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [rpsg_pkg::CfgDataW-1:0]         cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [rpsg_pkg::PosW-1:0]      s_position,
    input  logic                                  s_rand_direction,
    input  logic [rpsg_pkg::WordW-1:0]            s_rand_speed_word,
    input  logic [rpsg_pkg::WordW-1:0]            s_rand_time_word,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rpsg_pkg::Q8W-1:0]       m_speed_command_q8,
    output logic signed [rpsg_pkg::TargetW-1:0]   m_target_speed,
    output logic                                  m_edge_reversed
);

    rpsg_pkg::cfg_t       cfg;
    rpsg_pkg::dp_cmd_t    cmd;
    rpsg_pkg::dp_status_t status;

    // configuration registers
    rpsg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // sequencer
    rpsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // arithmetic and patrol state
    rpsg_datapath u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg                (cfg),
        .cmd                (cmd),
        .status             (status),
        .s_position         (s_position),
        .s_rand_direction   (s_rand_direction),
        .s_rand_speed_word  (s_rand_speed_word),
        .s_rand_time_word   (s_rand_time_word),
        .m_speed_command_q8 (m_speed_command_q8),
        .m_target_speed     (m_target_speed),
        .m_edge_reversed    (m_edge_reversed)
    );

endmodule
